@@ rtl/core/qcsf_pkg.sv @@
`timescale 1ns / 1ps
package qcsf_pkg;

  localparam int unsigned CoefW = 32;
  localparam int unsigned SumW  = 63;
  localparam logic [SumW-1:0] Max63 = {SumW{1'b1}};

  // Configuration register indexes.
  localparam logic [2:0] RegCoefX4 = 3'd0;
  localparam logic [2:0] RegCoefX3 = 3'd1;
  localparam logic [2:0] RegCoefX2 = 3'd2;
  localparam logic [2:0] RegCoefX1 = 3'd3;
  localparam logic [2:0] RegCoefX0 = 3'd4;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] sigma_value;
    logic               last_point;
  } qcsf_in_t;

  typedef struct packed {
    logic [62:0] chi_square;
    logic [62:0] fitness;
    logic        overflow_flag;
  } qcsf_out_t;

endpackage

@@ rtl/core/quartic_chi_square_fitness.sv @@
`timescale 1ns / 1ps
// Each point passes through four Horner multiplies, the division of the residual by
// sigma, squaring and accumulation; a last point also runs the reciprocal division
// before its result is offered. A term that saturates before squaring skips squaring.
// One point at a time: a new point is accepted only once the block is back in idle,
// as the bit-serial multiplier and divider serve each point in turn.
// Reset (rst, synchronous) clears the coefficients, the sum and the sticky flag.
module quartic_chi_square_fitness import qcsf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  qcsf_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output qcsf_out_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0, S_HORN = 3'd1, S_QDIV = 3'd2,
                         S_SQ = 3'd3, S_ACC = 3'd4, S_RDIV = 3'd5, S_OUT = 3'd6;
  localparam int Sh = 48 - 2 * FRAC_BITS;

  logic [2:0]  state;
  logic signed [31:0] coef [5];
  qcsf_in_t    pt;
  logic signed [31:0] acc;
  logic [2:0]  k;
  logic [62:0] sum;
  logic        sticky;
  logic [63:0] term;

  logic        mstart, mdone, dstart, ddone;
  logic signed [32:0] ma, mb;
  logic signed [63:0] mprod;
  logic [96:0] dnum, dquo;
  logic [63:0] dden;

  qcsf_serial_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb),
                         .done(mdone), .prod(mprod));
  qcsf_serial_div u_div (.clk, .rst, .start(dstart), .num(dnum), .den(dden),
                         .done(ddone), .quo(dquo));

  // Horner step combinational pieces.
  logic signed [64:0] hsum;
  logic signed [31:0] hsat;
  logic        hclip;
  logic signed [33:0] resid;
  logic [33:0] rmag, smag;
  logic [31:0] qmag;
  logic        qbig;
  logic [63:0] sq_shift;
  logic [63:0] sum_add;

  always_comb begin
    hsum     = 65'(mprod >>> FRAC_BITS) + 65'(coef[k]);
    if (hsum > 65'sh7FFFFFFF) begin
      hsat  = 32'sh7FFFFFFF;
      hclip = 1'b1;
    end else if (hsum < -65'sh80000000) begin
      hsat  = 32'h80000000;
      hclip = 1'b1;
    end else begin
      hsat  = hsum[31:0];
      hclip = 1'b0;
    end
    resid    = 34'(pt.y_value) - 34'(acc);
    rmag     = resid[33] ? 34'(-resid) : 34'(resid);
    smag     = pt.sigma_value[31] ? 34'(-34'(pt.sigma_value)) : 34'(pt.sigma_value);
    qbig     = |dquo[96:32];
    qmag     = dquo[31:0];
    sq_shift = 64'(mprod) << Sh;
    sum_add  = {1'b0, sum} + term;
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sum    <= '0;
      sticky <= 1'b0;
      mstart <= 1'b0;
      dstart <= 1'b0;
      for (int i = 0; i < 5; i++) coef[i] <= '0;
    end else begin
      mstart <= 1'b0;
      dstart <= 1'b0;
      if (cfg_we && cfg_index <= RegCoefX0) coef[cfg_index] <= cfg_data;
      case (state)
        S_IDLE: if (in_valid) begin
          pt <= in_data; acc <= coef[0]; k <= 3'd1;
          ma <= {coef[0][31], coef[0]};
          mb <= {in_data.x_value[31], in_data.x_value}; mstart <= 1'b1;
          state <= S_HORN;
        end
        S_HORN: if (mdone) begin
          // Saturate each Horner step to 32 bits.
          acc <= hsat;
          if (hclip) sticky <= 1'b1;
          if (k == 3'd4) begin
            state <= S_QDIV;
            dstart <= 1'b1;
          end else begin
            ma <= {hsat[31], hsat};
            mb <= {pt.x_value[31], pt.x_value}; mstart <= 1'b1; k <= k + 3'd1;
          end
        end
        S_QDIV: begin
          if (!dstart && ddone) begin
            if (smag == 34'd0 || qbig) begin
              term <= {1'b0, Max63}; sticky <= 1'b1; state <= S_ACC;
            end else begin
              ma <= {1'b0, qmag}; mb <= {1'b0, qmag}; state <= S_SQ;
              mstart <= 1'b1;
            end
          end
        end
        S_SQ: if (mdone) begin
          if ((64'(mprod) >> (63 - Sh)) != 64'd0) begin
            term <= {1'b0, Max63}; sticky <= 1'b1;
          end else term <= sq_shift;
          state <= S_ACC;
        end
        S_ACC: begin
          if (sum_add[63]) begin sum <= Max63; sticky <= 1'b1; end
          else sum <= sum_add[62:0];
          if (pt.last_point) begin state <= S_RDIV; dstart <= 1'b1; end
          else state <= S_IDLE;
        end
        S_RDIV: if (!dstart && ddone) begin
          out_data.chi_square <= sum;
          if ({1'b0, sum} <= 64'h200000000) begin
            out_data.fitness <= Max63; out_data.overflow_flag <= 1'b1;
          end else begin
            out_data.fitness <= dquo[62:0]; out_data.overflow_flag <= sticky;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          sum <= '0; sticky <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider operands depend on the phase.
  always_comb begin
    if (state == S_RDIV) begin
      dnum = {1'b1, 96'd0};
      dden = {1'b0, sum};
    end else begin
      dnum = 97'(rmag) << FRAC_BITS;
      dden = 64'(smag);
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && !pt.last_point) |=> in_ready)
    else $error("did not return to idle after point");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

@@ rtl/core/qcsf_serial_mul.sv @@
`timescale 1ns / 1ps
// Shift-and-add signed multiplier: one multiplier bit per cycle over 33 bits.
// Operands are 33 bits wide so that an unsigned 32-bit value can be squared.
module qcsf_serial_mul import qcsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic               done,
  output logic signed [63:0] prod
);

  logic [63:0] mcand;
  logic [32:0] mplier;
  logic [63:0] acc;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;

  assign prod = neg ? -$signed(acc) : $signed(acc);

  // Magnitudes are multiplied and the sign fixed at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= 6'd0;
        acc    <= 64'd0;
        neg    <= a[32] ^ b[32];
        mcand  <= {31'd0, (a[32] ? 33'(-a) : 33'(a))};
        mplier <= b[32] ? 33'(-b) : 33'(b);
      end else if (busy) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/qcsf_serial_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle over 97 bits.
module qcsf_serial_div import qcsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [96:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [96:0] quo
);

  logic [96:0] n;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem[63:0], n[96]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        n    <= num;
        rem  <= 65'd0;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[95:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[95:0], 1'b0};
        end
        n   <= n << 1;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd96) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import qcsf_pkg::*;

  localparam int FracBits = 16;

  // Tracks the coefficients and the running sum, and holds the expected
  // result of every data set whose last point has been accepted.
  class fitness_scoreboard;
    logic signed [31:0] coef [5];
    logic [62:0] run_sum;
    logic run_flag;
    qcsf_out_t expected_sets[$];
    int errors;
    int sets_checked;
    int sets_flagged;

    function new();
      for (int k = 0; k < 5; k++) coef[k] = '0;
      run_sum = '0;
      run_flag = 1'b0;
      errors = 0;
      sets_checked = 0;
      sets_flagged = 0;
    endfunction

    function void set_coef(int idx, logic [31:0] value);
      if (idx < 5) coef[idx] = value;
    endfunction

    function int pending();
      return expected_sets.size();
    endfunction

    function longint clip_word(longint v);
      if (v > 64'sh7FFF_FFFF) begin
        run_flag = 1'b1;
        return 64'sh7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
        run_flag = 1'b1;
        return -64'sh8000_0000;
      end
      return v;
    endfunction

    // Weighted squared residual of one point, in Q15.48.
    function logic [62:0] residual_term(logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] s);
      longint model;
      longint resid;
      longint quot;
      longint unsigned mag;
      longint unsigned sq;
      int unsigned sh;
      sh = 48 - 2 * FracBits;
      model = longint'(coef[0]);
      for (int k = 1; k < 5; k++)
        model = clip_word(((model * longint'(x)) >>> FracBits) + longint'(coef[k]));
      // Zero uncertainty saturates the term.
      if (s == 0) begin
        run_flag = 1'b1;
        return Max63;
      end
      resid = longint'(y) - model;
      quot = (resid * (longint'(1) << FracBits)) / longint'(s);
      mag = (quot < 0) ? longint'(0) - quot : quot;
      if (mag >= 64'h1_0000_0000) begin
        run_flag = 1'b1;
        return Max63;
      end
      sq = mag * mag;
      if (sq > ({1'b0, Max63} >> sh)) begin
        run_flag = 1'b1;
        return Max63;
      end
      return 63'(sq << sh);
    endfunction

    function void note_point(qcsf_in_t p);
      logic [62:0] term;
      logic [127:0] recip;
      qcsf_out_t res;
      term = residual_term(p.x_value, p.y_value, p.sigma_value);
      if (term > Max63 - run_sum) begin
        run_sum = Max63;
        run_flag = 1'b1;
      end else begin
        run_sum = run_sum + term;
      end
      if (p.last_point) begin
        // A zero or tiny sum would overflow the reciprocal.
        if (run_sum <= 63'h2_0000_0000) begin
          run_flag = 1'b1;
          recip = {65'd0, Max63};
        end else begin
          recip = (128'd1 << 96) / {65'd0, run_sum};
        end
        res.chi_square = run_sum;
        res.fitness = recip[62:0];
        res.overflow_flag = run_flag;
        expected_sets.insert(expected_sets.size(), res);
        run_sum = '0;
        run_flag = 1'b0;
      end
    endfunction

    function void check_result(qcsf_out_t got);
      qcsf_out_t want;
      if (expected_sets.size() == 0) begin
        $display("%0t: unexpected result chi_square=%h fitness=%h flag=%b",
                 $time, got.chi_square, got.fitness, got.overflow_flag);
        errors++;
        return;
      end
      want = expected_sets.pop_front();
      sets_checked++;
      if (want.overflow_flag) sets_flagged++;
      if (got.chi_square !== want.chi_square) begin
        $display("%0t: chi_square expected %h actual %h", $time, want.chi_square,
                 got.chi_square);
        errors++;
      end
      if (got.fitness !== want.fitness) begin
        $display("%0t: fitness expected %h actual %h", $time, want.fitness, got.fitness);
        errors++;
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        $display("%0t: overflow_flag expected %b actual %b", $time, want.overflow_flag,
                 got.overflow_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  qcsf_in_t in_data;
  logic out_valid;
  logic out_ready;
  qcsf_out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  fitness_scoreboard sb;
  logic hold_req;
  logic stall_on;
  int points_sent;

  quartic_chi_square_fitness #(.FRAC_BITS(FracBits)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Every accepted result transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result side: random stalls, occasional long ones, and one long hold-off
  // on request while the sender keeps offering points.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (1500) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 199) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(20, 100)) @(negedge clk);
      end else begin
        out_ready = stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!stall_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function logic [31:0] pick_word(int near_scale);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'($signed($urandom_range(0, 2 * near_scale)) - near_scale);
    if (r < 85) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_point(qcsf_in_t p);
    in_data = p;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_point(p);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic send_and_idle(qcsf_in_t p);
    int gap;
    send_point(p);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_fields(logic [31:0] x, logic [31:0] y, logic [31:0] s, logic last);
    qcsf_in_t p;
    p.x_value = x;
    p.y_value = y;
    p.sigma_value = s;
    p.last_point = last;
    send_and_idle(p);
  endtask

  // Lets the block finish all work before the coefficients change.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    sb.set_coef(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_coefs(logic [31:0] c4, logic [31:0] c3, logic [31:0] c2,
                             logic [31:0] c1, logic [31:0] c0);
    write_reg(RegCoefX4, c4);
    write_reg(RegCoefX3, c3);
    write_reg(RegCoefX2, c2);
    write_reg(RegCoefX1, c1);
    write_reg(RegCoefX0, c0);
  endtask

  function logic [31:0] small_coef();
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  initial begin
    int scale;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    stall_on = 1'b1;
    points_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero coefficients, so the model is zero.
    send_fields(32'h0, 32'h0, 32'h0001_0000, 1'b1);           // zero sum
    send_fields(32'h0, 32'h0000_0100, 32'h0001_0000, 1'b1);   // tiny sum
    send_fields(32'h0, 32'h0001_0000, 32'h0001_0000, 1'b1);   // ordinary sum
    send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1);   // zero sigma
    send_fields(32'h8000_0000, 32'h8000_0000, 32'h1, 1'b0);   // oversize quotient
    send_fields(32'h1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_fields(32'h0, 32'h0001_0000, 32'h8000_0000, 1'b1);   // sum overflow
    send_fields(32'h0, 32'h0010_0000, 32'h7FFF_FFFF, 1'b0);
    send_fields(32'h0, 32'hFFF0_0000, 32'hFFFF_0000, 1'b1);
    drain();
    // Out-of-range register indexes are ignored.
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'h8000_0000);
    write_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_fields(32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 1'b1);   // Horner saturates high
    send_fields(32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 1'b1);
    drain();
    write_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_fields(32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 1'b1);   // Horner saturates low
    send_fields(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain();
    write_coefs(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);   // model x^2
    send_fields(32'h0002_0000, 32'h0004_8000, 32'h0000_8000, 1'b0);
    send_fields(32'hFFFE_0000, 32'h0003_0000, 32'hFFFF_8000, 1'b1);
    drain();

    // Random phases, each with its own coefficient setting.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_coefs(small_coef(), small_coef(), small_coef(), small_coef(),
                       small_coef());
        1: write_coefs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        2: write_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF);
        3: write_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        4: write_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000);
        default: write_coefs(small_coef(), small_coef(), 32'h0, small_coef(),
                             small_coef());
      endcase
      stall_on = (phase != 1);
      if (phase == 2) hold_req = 1'b1;
      scale = (phase == 3) ? (1 << 24) : (1 << 18);
      for (int n = 0; n < 120; n++) begin
        logic [31:0] s;
        case ($urandom_range(0, 19))
          0: s = 32'h0;
          1, 2, 3, 4: s = $urandom();
          default: s = 32'($signed($urandom_range(1, 1 << 17)) *
                          ($urandom_range(0, 1) ? 1 : -1));
        endcase
        send_fields(pick_word(scale), pick_word(scale), s,
                    (n == 119) || ($urandom_range(0, 3) == 0));
      end
      drain();
    end

    in_valid = 1'b0;
    drain();
    $display("Sent %0d points; %0d data sets checked, %0d of them with the error flag.",
             points_sent, sb.sets_checked, sb.sets_flagged);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/qcsf_pkg.sv
rtl/core/qcsf_serial_mul.sv
rtl/core/qcsf_serial_div.sv
rtl/core/quartic_chi_square_fitness.sv
verif/tb.sv
